@@ rtl/mbfr_pkg.sv @@
// Shared types, constants and helper functions for the Modbus frame receiver.
package mbfr_pkg;

   // Framing mode codes held in the mode register
   localparam logic [1:0] MODE_RTU   = 2'd0;
   localparam logic [1:0] MODE_ASCII = 2'd1;
   localparam logic [1:0] MODE_TCP   = 2'd2;

   // Verdict error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SHORT = 2'd1;
   localparam logic [1:0] ERR_CHECK = 2'd2;
   localparam logic [1:0] ERR_HEX   = 2'd3;

   // Framing characters and frame geometry
   localparam logic [7:0]  CHAR_COLON    = 8'h3A;
   localparam logic [7:0]  CHAR_CR       = 8'h0D;
   localparam logic [7:0]  CHAR_LF       = 8'h0A;
   localparam logic [15:0] RTU_MIN_BYTES = 16'd4;
   localparam logic [15:0] TCP_LEN_HI    = 16'd4;
   localparam logic [15:0] TCP_LEN_LO    = 16'd5;
   localparam logic [15:0] TCP_HDR_BYTES = 16'd6;
   localparam logic [1:0]  LEAD_MAX      = 2'd3;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;

   // Result queue depth
   localparam int RESULT_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RTU,
      PH_ASCII,
      PH_TCP_HDR,
      PH_TCP_BODY
   } phase_type;

   typedef struct packed {
      logic [7:0]  pdu_byte;
      logic        is_verdict;
      logic        frame_ok;
      logic [1:0]  error_code;
      logic [7:0]  slave_address;
      logic [7:0]  function_code;
      logic [15:0] pdu_length;
      logic [15:0] frame_byte_count;
   } result_type;

   // Up to two results per request: a data byte first, then a verdict
   typedef struct packed {
      logic       data_valid;
      logic       verdict_valid;
      result_type data_item;
      result_type verdict_item;
   } push_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // Reflected CRC-16, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Hex digit decode: {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic result_type make_data(input logic [7:0] b);
      result_type r;
      r = '0;
      r.pdu_byte = b;
      return r;
   endfunction

   function automatic result_type make_verdict(input logic [1:0] err,
                                               input logic [7:0] slave,
                                               input logic [7:0] func,
                                               input logic [15:0] pdu_len,
                                               input logic [15:0] raw_len);
      result_type r;
      r.pdu_byte         = 8'd0;
      r.is_verdict       = 1'b1;
      r.frame_ok         = (err == ERR_NONE);
      r.error_code       = err;
      r.slave_address    = slave;
      r.function_code    = func;
      r.pdu_length       = pdu_len;
      r.frame_byte_count = raw_len;
      return r;
   endfunction

endpackage

@@ rtl/mbfr_decoder.sv @@
// Per-byte framing state machine: RTU, ASCII and TCP decode with CRC and LRC checks.
module mbfr_decoder
   import mbfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic       gap_marker,
   input  logic       cfg_write,
   input  logic [1:0] cfg_mode,
   output push_type   push
);

   logic [1:0]  mode_ff, mode_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] raw_count_ff, raw_count_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  lrc_ff, lrc_in;
   logic [7:0]  hold0_ff, hold0_in;
   logic [7:0]  hold1_ff, hold1_in;
   logic [3:0]  nib_high_ff, nib_high_in;
   logic        nib_pend_ff, nib_pend_in;
   logic [15:0] tcp_len_ff, tcp_len_in;
   logic [7:0]  slave_ff, slave_in;
   logic [7:0]  func_ff, func_in;
   logic        bad_ff, bad_in;
   logic        cr_ff, cr_in;
   logic [1:0]  lead_ff, lead_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RTU;
         phase_ff      <= PH_IDLE;
         raw_count_ff  <= '0;
         byte_count_ff <= '0;
         crc_ff        <= CRC_INIT;
         lrc_ff        <= '0;
         hold0_ff      <= '0;
         hold1_ff      <= '0;
         nib_high_ff   <= '0;
         nib_pend_ff   <= 1'b0;
         tcp_len_ff    <= '0;
         slave_ff      <= '0;
         func_ff       <= '0;
         bad_ff        <= 1'b0;
         cr_ff         <= 1'b0;
         lead_ff       <= '0;
      end else begin
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         raw_count_ff  <= raw_count_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         lrc_ff        <= lrc_in;
         hold0_ff      <= hold0_in;
         hold1_ff      <= hold1_in;
         nib_high_ff   <= nib_high_in;
         nib_pend_ff   <= nib_pend_in;
         tcp_len_ff    <= tcp_len_in;
         slave_ff      <= slave_in;
         func_ff       <= func_in;
         bad_ff        <= bad_in;
         cr_ff         <= cr_in;
         lead_ff       <= lead_in;
      end
   end

   // Next state and results for one request
   always_comb begin
      logic       clear;
      logic [4:0] hex;
      logic [7:0] dbyte;
      logic [1:0] err;

      clear = 1'b0;
      hex   = hex_decode(rx_byte);
      dbyte = {nib_high_ff, hex[3:0]};
      err   = ERR_NONE;

      mode_in       = mode_ff;
      phase_in      = phase_ff;
      raw_count_in  = raw_count_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      lrc_in        = lrc_ff;
      hold0_in      = hold0_ff;
      hold1_in      = hold1_ff;
      nib_high_in   = nib_high_ff;
      nib_pend_in   = nib_pend_ff;
      tcp_len_in    = tcp_len_ff;
      slave_in      = slave_ff;
      func_in       = func_ff;
      bad_in        = bad_ff;
      cr_in         = cr_ff;
      lead_in       = lead_ff;
      push          = '0;

      if (cfg_write) begin
         mode_in = cfg_mode;
         clear   = 1'b1;
      end else if (step) begin
         unique case (mode_ff)
            MODE_RTU: begin
               if (gap_marker) begin
                  if (phase_ff != PH_IDLE) begin
                     if (raw_count_ff < RTU_MIN_BYTES) begin
                        err = ERR_SHORT;
                     end else if (crc_ff != {hold1_ff, hold0_ff}) begin
                        err = ERR_CHECK;
                     end
                     push.verdict_valid = 1'b1;
                     push.verdict_item  = make_verdict(err, slave_ff, func_ff,
                                                       byte_count_ff, raw_count_ff);
                     clear = 1'b1;
                  end
               end else begin
                  phase_in = PH_RTU;
                  if (raw_count_ff == 16'd0) begin
                     slave_in = rx_byte;
                  end else if (raw_count_ff == 16'd1) begin
                     func_in = rx_byte;
                  end
                  // Byte leaving the two-byte hold line enters the CRC
                  if (raw_count_ff >= 16'd2) begin
                     crc_in = crc_byte(crc_ff, hold0_ff);
                     if (raw_count_ff >= RTU_MIN_BYTES) begin
                        push.data_valid = 1'b1;
                        push.data_item  = make_data(hold0_ff);
                        byte_count_in   = sat_inc(byte_count_ff);
                     end
                  end
                  hold0_in     = hold1_ff;
                  hold1_in     = rx_byte;
                  raw_count_in = sat_inc(raw_count_ff);
               end
            end
            MODE_ASCII: begin
               if (phase_ff == PH_IDLE) begin
                  if (rx_byte == CHAR_COLON) begin
                     phase_in     = PH_ASCII;
                     raw_count_in = 16'd1;
                  end
               end else begin
                  raw_count_in = sat_inc(raw_count_ff);
                  if (rx_byte == CHAR_LF && cr_ff) begin
                     if (bad_ff || nib_pend_ff) begin
                        err = ERR_HEX;
                     end else if (lead_ff < LEAD_MAX) begin
                        err = ERR_SHORT;
                     end else if (lrc_ff != 8'd0) begin
                        err = ERR_CHECK;
                     end
                     push.verdict_valid = 1'b1;
                     push.verdict_item  = make_verdict(err, slave_ff, func_ff,
                                                       byte_count_ff, raw_count_in);
                     clear = 1'b1;
                  end else if (rx_byte == CHAR_CR) begin
                     // A CR right after a CR is a stray one
                     bad_in = bad_ff | cr_ff;
                     cr_in  = 1'b1;
                  end else begin
                     cr_in  = 1'b0;
                     bad_in = bad_ff | cr_ff;
                     if (!(bad_ff || cr_ff)) begin
                        if (!hex[4]) begin
                           bad_in = 1'b1;
                        end else if (!nib_pend_ff) begin
                           nib_high_in = hex[3:0];
                           nib_pend_in = 1'b1;
                        end else begin
                           nib_pend_in = 1'b0;
                           lrc_in      = lrc_ff + dbyte;
                           if (lead_ff == 2'd0) begin
                              slave_in = dbyte;
                           end else if (lead_ff == 2'd1) begin
                              func_in = dbyte;
                           end
                           if (lead_ff == LEAD_MAX) begin
                              push.data_valid = 1'b1;
                              push.data_item  = make_data(hold0_ff);
                              byte_count_in   = sat_inc(byte_count_ff);
                           end else begin
                              lead_in = lead_ff + 2'd1;
                           end
                           hold0_in = dbyte;
                        end
                     end
                  end
               end
            end
            MODE_TCP: begin
               if (phase_ff == PH_IDLE || phase_ff == PH_TCP_HDR) begin
                  phase_in = PH_TCP_HDR;
                  if (raw_count_ff == TCP_LEN_HI) begin
                     tcp_len_in = {rx_byte, 8'd0};
                  end else if (raw_count_ff == TCP_LEN_LO) begin
                     tcp_len_in = {tcp_len_ff[15:8], rx_byte};
                  end
                  raw_count_in = sat_inc(raw_count_ff);
                  if (raw_count_in == TCP_HDR_BYTES) begin
                     if (tcp_len_in == 16'd0) begin
                        push.verdict_valid = 1'b1;
                        push.verdict_item  = make_verdict(ERR_SHORT, slave_ff, func_ff,
                                                          byte_count_ff, raw_count_in);
                        clear = 1'b1;
                     end else begin
                        phase_in = PH_TCP_BODY;
                     end
                  end
               end else begin
                  raw_count_in = sat_inc(raw_count_ff);
                  if (lead_ff == 2'd0) begin
                     slave_in = rx_byte;
                  end else if (lead_ff == 2'd1) begin
                     func_in = rx_byte;
                  end else begin
                     push.data_valid = 1'b1;
                     push.data_item  = make_data(rx_byte);
                     byte_count_in   = sat_inc(byte_count_ff);
                  end
                  if (lead_ff != LEAD_MAX) begin
                     lead_in = lead_ff + 2'd1;
                  end
                  tcp_len_in = tcp_len_ff - 16'd1;
                  if (tcp_len_in == 16'd0) begin
                     err = (lead_in < 2'd2) ? ERR_SHORT : ERR_NONE;
                     push.verdict_valid = 1'b1;
                     push.verdict_item  = make_verdict(err, slave_in, func_in,
                                                       byte_count_in, raw_count_in);
                     clear = 1'b1;
                  end
               end
            end
            default: begin
               // Unused mode code: bytes are dropped
            end
         endcase
      end

      // End of frame or mode change: back to the start state
      if (clear) begin
         phase_in      = PH_IDLE;
         raw_count_in  = '0;
         byte_count_in = '0;
         crc_in        = CRC_INIT;
         lrc_in        = '0;
         hold0_in      = '0;
         hold1_in      = '0;
         nib_high_in   = '0;
         nib_pend_in   = 1'b0;
         tcp_len_in    = '0;
         slave_in      = '0;
         func_in       = '0;
         bad_in        = 1'b0;
         cr_in         = 1'b0;
         lead_in       = '0;
      end
   end

   // A verdict always returns the framer to its start state
   assert property (@(posedge clock) disable iff (reset)
      push.verdict_valid |=> (phase_ff == PH_IDLE && raw_count_ff == 16'd0))
      else $error("framer state not cleared after verdict");

   // Data bytes only come out of a frame already in progress
   assert property (@(posedge clock) disable iff (reset)
      push.data_valid |-> (phase_ff != PH_IDLE))
      else $error("data byte emitted outside a frame");

endmodule

@@ rtl/mbfr_result_fifo.sv @@
// Small result queue taking up to two results per cycle and delivering one.
module mbfr_result_fifo
   import mbfr_pkg::*;
#(
   parameter int DEPTH = RESULT_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output logic       not_empty,
   output logic       room_for_two,
   output result_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   result_type    entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;
   logic [PW-1:0] verdict_slot;
   logic          do_pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == LAST) ? '0 : p + PW'(1);
   endfunction

   assign wr_next      = ptr_inc(wr_ptr_ff);
   assign verdict_slot = push.data_valid ? wr_next : wr_ptr_ff;
   assign do_pop       = pop && (count_ff != '0);
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= CW'(DEPTH - 2));
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.data_valid && push.verdict_valid) begin
         wr_ptr_in = ptr_inc(wr_next);
      end else if (push.data_valid || push.verdict_valid) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.data_valid) + CW'(push.verdict_valid)
                  - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage: data first, verdict behind it
   always_ff @(posedge clock) begin
      if (push.data_valid) begin
         entry_ff[wr_ptr_ff] <= push.data_item;
      end
      if (push.verdict_valid) begin
         entry_ff[verdict_slot] <= push.verdict_item;
      end
   end

   // Never overfilled
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overflow");

   // Pointers stay consistent with the fill count
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers out of step");

   // The head entry holds while it waits to be taken
   assert property (@(posedge clock) disable iff (reset)
      (not_empty && !pop) |=> $stable(rd_ptr_ff))
      else $error("result queue head moved without a pop");

endmodule

@@ rtl/modbus_frame_receiver.sv @@
// Modbus RTU/ASCII/TCP frame receiver top level: request and result channels, mode register.
//
// One received byte per request, one request per clock unless req_stall is high.
// Each byte is decoded by combinational logic (CRC-16, LRC and hex decode) and
// its results, at most a data byte and a frame verdict, are registered in a
// RESULT_DEPTH-entry result queue that delivers one result per clock unless
// rsp_stall is high. A request is taken whenever the queue has room for two
// results and no mode write is offered, so with the result side free the block
// accepts a byte every cycle; a TCP body byte that is a data byte and closes the
// frame yields two results. The mode register (0 RTU, 1 ASCII, 2 TCP; 3 drops
// all bytes) is always writable, holds off requests in the cycle it is written
// and drops any frame in progress; write it only while no results are
// outstanding.
module modbus_frame_receiver
   import mbfr_pkg::*;
#(
   parameter int RESULT_QUEUE_DEPTH = RESULT_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_gap_marker,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pdu_byte,
   output logic        rsp_is_verdict,
   output logic        rsp_frame_ok,
   output logic [1:0]  rsp_error_code,
   output logic [7:0]  rsp_slave_address,
   output logic [7:0]  rsp_function_code,
   output logic [15:0] rsp_pdu_length,
   output logic [15:0] rsp_frame_byte_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   push_type   push;
   result_type head;
   logic       room_for_two;
   logic       req_take;
   logic       csr_take;

   // Request handshake; a mode write holds off the request side
   assign req_stall = !room_for_two || csr_valid;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;

   mbfr_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step       (req_take),
      .rx_byte    (req_rx_byte),
      .gap_marker (req_gap_marker),
      .cfg_write  (csr_take),
      .cfg_mode   (csr_data),
      .push       (push)
   );

   mbfr_result_fifo #(
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (!rsp_stall),
      .not_empty    (rsp_valid),
      .room_for_two (room_for_two),
      .head         (head)
   );

   // Result fields
   assign rsp_pdu_byte         = head.pdu_byte;
   assign rsp_is_verdict       = head.is_verdict;
   assign rsp_frame_ok         = head.frame_ok;
   assign rsp_error_code       = head.error_code;
   assign rsp_slave_address    = head.slave_address;
   assign rsp_function_code    = head.function_code;
   assign rsp_pdu_length       = head.pdu_length;
   assign rsp_frame_byte_count = head.frame_byte_count;

endmodule

@@ sim/modbus_frame_receiver_tb.sv @@
// Self-checking testbench for the Modbus RTU/ASCII/TCP frame receiver.
module modbus_frame_receiver_tb;
   import mbfr_pkg::*;

   localparam logic [1:0] MODE_OFF = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_REQUESTS = 230;
   localparam int TAIL_REQUESTS = 100;
   localparam int PRINT_CAP = 40;

   typedef logic [7:0] octet_queue_type[$];
   typedef enum {FLAW_NONE, FLAW_CHECK, FLAW_CHAR, FLAW_COLON, FLAW_LONE_CR, FLAW_ODD} flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_gap_marker = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pdu_byte;
   logic        rsp_is_verdict;
   logic        rsp_frame_ok;
   logic [1:0]  rsp_error_code;
   logic [7:0]  rsp_slave_address;
   logic [7:0]  rsp_function_code;
   logic [15:0] rsp_pdu_length;
   logic [15:0] rsp_frame_byte_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = 2'd0;

   modbus_frame_receiver dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .req_gap_marker      (req_gap_marker),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pdu_byte        (rsp_pdu_byte),
      .rsp_is_verdict      (rsp_is_verdict),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_error_code      (rsp_error_code),
      .rsp_slave_address   (rsp_slave_address),
      .rsp_function_code   (rsp_function_code),
      .rsp_pdu_length      (rsp_pdu_length),
      .rsp_frame_byte_count(rsp_frame_byte_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   // Free-running clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run bookkeeping
   int  cycles = 0;
   int  mismatches = 0;
   int  requests_sent = 0;
   int  results_checked = 0;
   int  verdicts_checked = 0;
   int  good_frames = 0;
   bit  idle_en = 1'b1;
   bit  req_live = 1'b0;
   int  stall_left = 0;
   result_type pending_results[$];

   // Frame decoder state mirrored by the predictor
   logic [1:0]  m_mode;
   phase_type   m_phase;
   logic [15:0] m_raw, m_pdu, m_crc, m_left;
   logic [7:0]  m_lrc, m_hold0, m_hold1, m_slave, m_func;
   logic [3:0]  m_nib;
   logic        m_nib_pend, m_bad, m_cr;
   logic [1:0]  m_lead;

   function automatic logic [15:0] sat_up(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // {valid, value} of an ASCII hex digit, either case
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      return 5'd0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'("0") + 8'(n);
      return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
   endfunction

   function automatic void clear_frame_state();
      m_phase = PH_IDLE;
      m_raw = '0;
      m_pdu = '0;
      m_crc = CRC_INIT;
      m_lrc = '0;
      m_hold0 = '0;
      m_hold1 = '0;
      m_nib = '0;
      m_nib_pend = 1'b0;
      m_left = '0;
      m_slave = '0;
      m_func = '0;
      m_bad = 1'b0;
      m_cr = 1'b0;
      m_lead = '0;
   endfunction

   function automatic void emit_data(input logic [7:0] b);
      result_type r;
      r = '0;
      r.pdu_byte = b;
      pending_results.push_back(r);
      m_pdu = sat_up(m_pdu);
   endfunction

   function automatic void emit_verdict(input logic [1:0] err);
      result_type r;
      r.pdu_byte         = 8'h00;
      r.is_verdict       = 1'b1;
      r.frame_ok         = (err == ERR_NONE);
      r.error_code       = err;
      r.slave_address    = m_slave;
      r.function_code    = m_func;
      r.pdu_length       = m_pdu;
      r.frame_byte_count = m_raw;
      pending_results.push_back(r);
      clear_frame_state();
   endfunction

   // RTU: two-byte delay line holds back the CRC until the gap closes the frame
   function automatic void decode_rtu(input logic [7:0] b, input logic gap);
      if (gap) begin
         if (m_phase == PH_IDLE) return;
         if (m_raw < RTU_MIN_BYTES) emit_verdict(ERR_SHORT);
         else emit_verdict((m_crc == {m_hold1, m_hold0}) ? ERR_NONE : ERR_CHECK);
         return;
      end
      m_phase = PH_RTU;
      if (m_raw == 16'd0) m_slave = b;
      else if (m_raw == 16'd1) m_func = b;
      if (m_raw >= 16'd2) begin
         m_crc = crc_step(m_crc, m_hold0);
         if (m_raw >= RTU_MIN_BYTES) emit_data(m_hold0);
      end
      m_hold0 = m_hold1;
      m_hold1 = b;
      m_raw = sat_up(m_raw);
   endfunction

   // ASCII: colon opens, CRLF closes, the last decoded byte is the LRC
   function automatic void decode_ascii(input logic [7:0] c);
      logic [4:0] hv;
      logic [7:0] val;
      logic [1:0] err;
      if (m_phase == PH_IDLE) begin
         if (c == CHAR_COLON) begin
            m_phase = PH_ASCII;
            m_raw = 16'd1;
         end
         return;
      end
      m_raw = sat_up(m_raw);
      if (c == CHAR_LF && m_cr) begin
         if (m_bad || m_nib_pend) err = ERR_HEX;
         else if (m_lead < LEAD_MAX) err = ERR_SHORT;
         else if (m_lrc != 8'h00) err = ERR_CHECK;
         else err = ERR_NONE;
         emit_verdict(err);
         return;
      end
      if (m_cr) begin
         m_bad = 1'b1;
         m_cr = 1'b0;
      end
      if (c == CHAR_CR) begin
         m_cr = 1'b1;
         return;
      end
      if (m_bad) return;
      hv = hex_nibble(c);
      if (!hv[4]) begin
         m_bad = 1'b1;
         return;
      end
      if (!m_nib_pend) begin
         m_nib = hv[3:0];
         m_nib_pend = 1'b1;
         return;
      end
      m_nib_pend = 1'b0;
      val = {m_nib, hv[3:0]};
      m_lrc = m_lrc + val;
      if (m_lead == 2'd0) m_slave = val;
      else if (m_lead == 2'd1) m_func = val;
      if (m_lead >= LEAD_MAX) emit_data(m_hold0);
      m_hold0 = val;
      if (m_lead < LEAD_MAX) m_lead = m_lead + 2'd1;
   endfunction

   // TCP: MBAP length field counts the body bytes still due
   function automatic void decode_tcp(input logic [7:0] b);
      if (m_phase == PH_IDLE || m_phase == PH_TCP_HDR) begin
         m_phase = PH_TCP_HDR;
         if (m_raw == TCP_LEN_HI) m_left = {b, 8'h00};
         else if (m_raw == TCP_LEN_LO) m_left = m_left | {8'h00, b};
         m_raw = sat_up(m_raw);
         if (m_raw == TCP_HDR_BYTES) begin
            if (m_left == 16'd0) begin
               emit_verdict(ERR_SHORT);
               return;
            end
            m_phase = PH_TCP_BODY;
         end
         return;
      end
      m_raw = sat_up(m_raw);
      if (m_lead == 2'd0) m_slave = b;
      else if (m_lead == 2'd1) m_func = b;
      else emit_data(b);
      if (m_lead < LEAD_MAX) m_lead = m_lead + 2'd1;
      m_left = m_left - 16'd1;
      if (m_left == 16'd0) emit_verdict((m_lead < 2'd2) ? ERR_SHORT : ERR_NONE);
   endfunction

   function automatic void decode_request(input logic [7:0] b, input logic gap);
      case (m_mode)
         MODE_RTU:   decode_rtu(b, gap);
         MODE_ASCII: decode_ascii(b);
         MODE_TCP:   decode_tcp(b);
         default:    ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Result side: random stall bursts and the checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycles, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (want.is_verdict) verdicts_checked++;
            if (want.frame_ok) good_frames++;
            check_field("pdu_byte", 16'(rsp_pdu_byte), 16'(want.pdu_byte));
            check_field("is_verdict", 16'(rsp_is_verdict), 16'(want.is_verdict));
            check_field("frame_ok", 16'(rsp_frame_ok), 16'(want.frame_ok));
            check_field("error_code", 16'(rsp_error_code), 16'(want.error_code));
            check_field("slave_address", 16'(rsp_slave_address), 16'(want.slave_address));
            check_field("function_code", 16'(rsp_function_code), 16'(want.function_code));
            check_field("pdu_length", rsp_pdu_length, want.pdu_length);
            check_field("frame_byte_count", rsp_frame_byte_count, want.frame_byte_count);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout with %0d results outstanding", pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic hold_off();
      if (req_live) begin
         req_valid <= 1'b0;
         req_live = 1'b0;
      end
   endtask

   // One request: optional idle burst, then hold until accepted
   task automatic send_byte(input logic [7:0] b, input logic gap);
      if (idle_en && $urandom_range(0, 7) == 0) begin
         hold_off();
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_gap_marker <= gap;
      req_live = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      requests_sent++;
      decode_request(b, gap);
   endtask

   task automatic wait_drain();
      hold_off();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Mode register write, only with the block quiet
   task automatic write_mode(input logic [1:0] mode);
      wait_drain();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      m_mode = mode;
      clear_frame_state();
   endtask

   function automatic bit noise_gap();
      return ($urandom_range(0, 7) == 0);
   endfunction

   function automatic octet_queue_type random_octets(input int n);
      octet_queue_type q;
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // Any byte but a colon; inside a frame also no hex digit and no CR
   function automatic logic [7:0] stray_char(input bit in_frame);
      logic [7:0] c;
      logic [4:0] hv;
      do begin
         c = 8'($urandom_range(0, 255));
         hv = hex_nibble(c);
      end while (c == CHAR_COLON || (in_frame && (hv[4] || c == CHAR_CR)));
      return c;
   endfunction

   // RTU frame: body, CRC low byte first, then a gap; bad_crc flips one bit
   task automatic send_rtu(input octet_queue_type body, input bit bad_crc);
      octet_queue_type fr;
      logic [15:0] c;
      int k;
      fr = body;
      c = CRC_INIT;
      foreach (body[i]) c = crc_step(c, body[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (bad_crc) begin
         k = $urandom_range(0, fr.size() - 1);
         fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (fr[i]) send_byte(fr[i], 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // ASCII frame with LRC; casing 0 upper, 1 lower, 2 mixed
   task automatic send_ascii(input octet_queue_type body, input flaw_type flaw, input int casing,
                             input int junk);
      octet_queue_type chars;
      logic [7:0] lrc;
      int k;
      lrc = 8'h00;
      foreach (body[i]) lrc = lrc - body[i];
      if (flaw == FLAW_CHECK) lrc = lrc ^ (8'h01 << $urandom_range(0, 7));
      body.push_back(lrc);
      foreach (body[i]) begin
         chars.push_back(hex_char(body[i][7:4],
                                  (casing == 2) ? bit'($urandom_range(0, 1)) : bit'(casing)));
         chars.push_back(hex_char(body[i][3:0],
                                  (casing == 2) ? bit'($urandom_range(0, 1)) : bit'(casing)));
      end
      k = $urandom_range(0, chars.size());
      case (flaw)
         FLAW_CHAR:    chars.insert(k, stray_char(1'b1));
         FLAW_COLON:   chars.insert(k, CHAR_COLON);
         FLAW_LONE_CR: chars.insert(k, CHAR_CR);
         FLAW_ODD:     chars.delete(k % chars.size());
         default:      ;
      endcase
      repeat (junk) send_byte(stray_char(1'b0), noise_gap());
      send_byte(CHAR_COLON, noise_gap());
      foreach (chars[i]) send_byte(chars[i], noise_gap());
      send_byte(CHAR_CR, noise_gap());
      send_byte(CHAR_LF, noise_gap());
   endtask

   // TCP frame: four random MBAP bytes, the length, then the body
   task automatic send_tcp(input logic [15:0] len);
      repeat (4) send_byte(8'($urandom_range(0, 255)), noise_gap());
      send_byte(len[15:8], noise_gap());
      send_byte(len[7:0], noise_gap());
      repeat (len) send_byte(8'($urandom_range(0, 255)), noise_gap());
   endtask

   // One random frame in the current mode, mostly well formed
   task automatic random_frame();
      int k;
      k = $urandom_range(0, 11);
      case (m_mode)
         MODE_RTU: begin
            if (k == 0) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
               send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else if (k == 1) begin
               send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
               send_rtu(random_octets(2 + $urandom_range(0, 8)), k == 2);
            end
         end
         MODE_ASCII: begin
            send_ascii(random_octets((k == 5) ? $urandom_range(0, 1) : 2 + $urandom_range(0, 6)),
                       (k == 0) ? FLAW_CHECK : (k == 1) ? FLAW_CHAR : (k == 2) ? FLAW_COLON :
                       (k == 3) ? FLAW_LONE_CR : (k == 4) ? FLAW_ODD : FLAW_NONE,
                       $urandom_range(0, 2),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
         end
         MODE_TCP: begin
            if (k == 0) send_tcp(16'd0);
            else if (k == 1) send_tcp(16'd1);
            else send_tcp(16'(2 + $urandom_range(0, 8)));
         end
         default: begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_rtu_frames();
      octet_queue_type fr;
      write_mode(MODE_RTU);
      send_byte(8'h5A, 1'b1);                 // gap with no frame open
      send_byte(8'hFF, 1'b0);                 // three bytes only: too short
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b1);
      fr = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55};
      send_rtu(fr, 1'b0);
      fr = {8'hFF, 8'h01};                    // minimal frame, empty PDU
      send_rtu(fr, 1'b0);
      fr = {8'h11, 8'h03, 8'h00, 8'h6B};
      send_rtu(fr, 1'b1);
   endtask

   task automatic test_ascii_frames();
      octet_queue_type fr;
      write_mode(MODE_ASCII);
      fr = {8'h01, 8'h03, 8'h00, 8'hFF};
      send_ascii(fr, FLAW_NONE, 0, 2);        // leading junk before the colon
      fr = {8'hFF, 8'h10, 8'hAB, 8'hCD};
      send_ascii(fr, FLAW_NONE, 1, 0);        // lower-case hex
      send_ascii(fr, FLAW_CHECK, 2, 0);
      send_ascii(fr, FLAW_CHAR, 2, 0);
      send_ascii(fr, FLAW_COLON, 2, 0);
      send_ascii(fr, FLAW_LONE_CR, 2, 0);
      send_ascii(fr, FLAW_ODD, 2, 0);
      fr = {8'h07};                           // slave plus LRC only: too short
      send_ascii(fr, FLAW_NONE, 0, 0);
   endtask

   task automatic test_tcp_frames();
      write_mode(MODE_TCP);
      send_tcp(16'd0);                        // ends at the header
      send_tcp(16'd1);                        // unit id only
      send_tcp(16'd2);
      send_tcp(16'd7);
      send_tcp(16'h0105);                     // length with a nonzero high byte
   endtask

   task automatic test_disabled_mode();
      write_mode(MODE_OFF);
      send_byte(CHAR_COLON, 1'b0);
      send_byte(8'h30, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte(CHAR_LF, 1'b1);
   endtask

   // A register write mid-frame drops the partial frame
   task automatic test_mode_write_drops_frame();
      octet_queue_type fr;
      write_mode(MODE_RTU);
      repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
      write_mode(MODE_RTU);
      fr = {8'h21, 8'h10, 8'h44};
      send_rtu(fr, 1'b0);
      write_mode(MODE_ASCII);
      send_byte(CHAR_COLON, 1'b0);
      send_byte(8'h30, 1'b0);
      send_byte(8'h31, 1'b0);
      write_mode(MODE_ASCII);
      send_ascii(fr, FLAW_NONE, 2, 0);
      write_mode(MODE_TCP);
      repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0);
      write_mode(MODE_TCP);
      send_tcp(16'd3);
   endtask

   task automatic test_random_traffic();
      logic [1:0] modes[4];
      int stop_at, phase_end;
      modes = '{MODE_RTU, MODE_ASCII, MODE_TCP, MODE_OFF};
      stop_at = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < stop_at) begin
         write_mode(($urandom_range(0, 7) == 0) ? modes[3] : modes[$urandom_range(0, 2)]);
         phase_end = requests_sent + ((m_mode == MODE_OFF) ? 20 : $urandom_range(60, 140));
         while (requests_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) idle_en = !idle_en;
            if ($urandom_range(0, 15) == 0) wait_drain();
            random_frame();
         end
      end
      idle_en = 1'b1;
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_quiet_tail();
      int phase_end;
      idle_en = 1'b0;
      write_mode(MODE_RTU);
      phase_end = requests_sent + TAIL_REQUESTS / 3;
      while (requests_sent < phase_end) random_frame();
      write_mode(MODE_ASCII);
      phase_end = requests_sent + TAIL_REQUESTS / 3;
      while (requests_sent < phase_end) random_frame();
      write_mode(MODE_TCP);
      phase_end = requests_sent + TAIL_REQUESTS / 3;
      while (requests_sent < phase_end) random_frame();
   endtask

   initial begin
      m_mode = MODE_RTU;
      clear_frame_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_rtu_frames();
      test_ascii_frames();
      test_tcp_frames();
      test_disabled_mode();
      test_mode_write_drops_frame();
      test_random_traffic();
      test_quiet_tail();
      wait_drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d request bytes over RTU, ASCII, TCP and disabled modes with random stalls.",
               requests_sent);
      $display("Checked %0d results: %0d frame verdicts, %0d frames accepted, %0d mismatches.",
               results_checked, verdicts_checked, good_frames, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mbfr_pkg.sv
rtl/mbfr_decoder.sv
rtl/mbfr_result_fifo.sv
rtl/modbus_frame_receiver.sv
sim/modbus_frame_receiver_tb.sv
